/* rtl/cs_pkg.sv */
// Package for the comment stripper: lexer modes, character codes, result
// item type and output queue sizing.
// No dependencies.
package cs_pkg;

  // Lexer modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } lex_mode_e;

  // Characters that steer the lexer.
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;
  } result_t;

  // Results produced by one input item: up to two, slot 0 first.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot1;
    result_t    slot0;
  } result_pair_t;

  // Output queue sizing.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

endpackage

/* rtl/cs_lexer.sv */
// Lexer state and per-byte decision logic of the comment stripper.
// Produces zero, one or two result items for each accepted byte.
// Depends on cs_pkg.
module cs_lexer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           in_char_i,
  input  logic                 in_last_i,
  output cs_pkg::result_pair_t results_o
);
  import cs_pkg::*;

  lex_mode_e mode_q, mode_d;
  logic      slash_held_q, slash_held_d;
  logic      star_seen_q, star_seen_d;
  logic      prev_bs_q, prev_bs_d;

  // Emission flags: flushed slash, current byte, slash held at end of text, empty end item.
  logic flush_slash, emit_byte, end_slash, pad;
  logic quote_open;

  // Next state and emission decisions for the current byte.
  always_comb begin
    mode_d       = mode_q;
    slash_held_d = slash_held_q;
    star_seen_d  = star_seen_q;
    flush_slash  = 1'b0;
    emit_byte    = 1'b0;
    quote_open   = (in_char_i == CH_QUOTE) && !prev_bs_q;
    case (mode_q)
      MODE_NORMAL: begin
        slash_held_d = 1'b0;
        if (slash_held_q && (in_char_i == CH_SLASH)) begin
          mode_d = MODE_LINE;
        end else if (slash_held_q && (in_char_i == CH_STAR)) begin
          mode_d      = MODE_BLOCK;
          star_seen_d = 1'b0;
        end else begin
          flush_slash = slash_held_q;
          if (quote_open) begin
            mode_d    = MODE_STRING;
            emit_byte = 1'b1;
          end else if (in_char_i == CH_SLASH) begin
            slash_held_d = 1'b1;
          end else begin
            emit_byte = 1'b1;
          end
        end
      end
      MODE_STRING: begin
        emit_byte = 1'b1;
        if (quote_open) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (in_char_i == CH_NEWLINE) begin
          mode_d    = MODE_NORMAL;
          emit_byte = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (star_seen_q && (in_char_i == CH_SLASH)) begin
          mode_d      = MODE_NORMAL;
          star_seen_d = 1'b0;
        end else begin
          emit_byte   = (in_char_i == CH_NEWLINE);
          star_seen_d = (in_char_i == CH_STAR);
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase
    prev_bs_d = (in_char_i == CH_BACKSLASH);
    end_slash = in_last_i && slash_held_d;
    pad       = in_last_i && !flush_slash && !emit_byte && !end_slash;
  end

  // Pack the emitted items into two slots in stream order.
  always_comb begin
    results_o = '0;
    results_o.count = 2'(flush_slash) + 2'(emit_byte) + 2'(end_slash) + 2'(pad);
    if (flush_slash) begin
      results_o.slot0 = '{out_char: CH_SLASH, has_char: 1'b1, out_last: 1'b0};
    end else if (emit_byte) begin
      results_o.slot0 = '{out_char: in_char_i, has_char: 1'b1, out_last: 1'b0};
    end else if (end_slash) begin
      results_o.slot0 = '{out_char: CH_SLASH, has_char: 1'b1, out_last: 1'b0};
    end else begin
      results_o.slot0 = '{out_char: 8'h00, has_char: 1'b0, out_last: 1'b0};
    end
    results_o.slot1.out_char = emit_byte ? in_char_i : CH_SLASH;
    results_o.slot1.has_char = 1'b1;
    results_o.slot1.out_last = in_last_i;
    results_o.slot0.out_last = in_last_i && (results_o.count == 2'd1);
  end

  // State registers; the end of text returns everything to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      slash_held_q <= 1'b0;
      star_seen_q  <= 1'b0;
      prev_bs_q    <= 1'b0;
    end else if (accept_i) begin
      if (in_last_i) begin
        mode_q       <= MODE_NORMAL;
        slash_held_q <= 1'b0;
        star_seen_q  <= 1'b0;
        prev_bs_q    <= 1'b0;
      end else begin
        mode_q       <= mode_d;
        slash_held_q <= slash_held_d;
        star_seen_q  <= star_seen_d;
        prev_bs_q    <= prev_bs_d;
      end
    end
  end

endmodule

/* rtl/cs_out_queue.sv */
// Small output queue of the comment stripper: takes up to two result items
// per cycle and hands one item per cycle to the receiver while it does not stall.
// Depends on cs_pkg.
module cs_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cs_pkg::result_pair_t results_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cs_pkg::result_t      head_o
);
  import cs_pkg::*;

  result_t               entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic [1:0]            push_cnt;
  logic                  pop;
  logic [QueuePtrW-1:0]  wr_ptr1;

  assign push_cnt    = push_i ? results_i.count : 2'd0;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = entry_q[rd_ptr_q];
  assign room_o      = (count_q <= QueueCntW'(QueueDepth - 2));
  assign wr_ptr1     = wr_ptr_q + QueuePtrW'(1);
  assign count_d     = count_q + QueueCntW'(push_cnt) - QueueCntW'(pop);

  // Entry storage, written at up to two consecutive places.
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      entry_q[wr_ptr_q] <= results_i.slot0;
    end
    if (push_cnt == 2'd2) begin
      entry_q[wr_ptr1] <= results_i.slot1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push_cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

/* rtl/comment_stripper.sv */
// Top level of the comment stripper: byte lexer followed by an output queue.
// Depends on cs_pkg, cs_lexer and cs_out_queue.
//
// Usage: source text enters one byte per item on the input channel
// (in_char_i, with in_last_i on the final byte). Kept bytes leave on the
// output channel; has_char_o marks whether out_char_o carries a byte, and
// out_last_o marks the last result item of a text. A stripped byte gives no
// result, except that the final byte always gives at least one.
// Each result item is registered in the queue before it reaches the output.
// Throughput: one byte per cycle while in_stall_o is low; a byte can
// cause two result items (a flushed slash plus the byte), and the output
// side moves one item per cycle while the receiver does not stall, so the
// four-entry queue sets the rate when many bytes in a row cause two items.
// Input stall is raised when the queue has fewer than two free entries.
// When the receiver stalls, the head item holds steady on the output and
// the queue absorbs new results until it fills.
// Reset clears the lexer to normal text and empties the queue. After a
// byte marked last, the lexer is back at its reset state for a new text.
module comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       has_char_o,
  output logic       out_last_o
);
  import cs_pkg::*;

  logic         accept;
  logic         room;
  result_pair_t results;
  result_t      head;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  // Per-byte lexer.
  cs_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (in_char_i),
    .in_last_i (in_last_i),
    .results_o (results)
  );

  // Result queue toward the receiver.
  cs_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .results_i   (results),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_char_o = head.out_char;
  assign has_char_o = head.has_char;
  assign out_last_o = head.out_last;

endmodule
